// ----- sv/drst_pkg.sv -----
// ----------------------------------------------------------------------------
// drst_pkg
// Shared types and constants for the dirty range sync tracker.
// ----------------------------------------------------------------------------
package drst_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ADDR_WIDTH_DEF  = 48;

    localparam int LEN_W      = 32;
    localparam int THR_W      = 32;
    localparam int SHIFT_W    = 5;
    localparam int UNSYNC_W   = 40;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;

    localparam logic [THR_W-1:0]   THRESHOLD_RST  = THR_W'(1048576);
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'(12);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_POS_OUT   = 2'd1,
        ST_WRITE_OUT = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_SIZE    = 2'd0,
        CFG_SYNC_THRESHOLD = 2'd1,
        CFG_PAGE_SHIFT     = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CMP   = 4'b0010,
        S_UPD   = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    // Queue occupancy seen by the front and back halves.
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- sv/dirty_range_sync_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty_range_sync_tracker
// Tracks dirty byte ranges of a mapped device and emits page aligned sync
// commands when the range table fills or the unsynced byte count is high.
// ----------------------------------------------------------------------------
// Usage:
// Write requests (position, length) enter on the input channel; the block
// raises o_in_stall only when its four-entry request queue is full. Each
// request yields one or more results on the output channel: a single status
// result (ok or out of device), or, on a flush, one sync command per stored
// range with o_last on the final one.
// A request is taken from the queue, compared with the table in the compare
// state and applied in the update state of the back end, which loads a plain
// result into the output register or starts a flush; without a flush the
// next queued request is taken in the update state. On a flush the walker
// reads one table entry per cycle while the output is not stalled, and the
// back end returns to idle before it takes the next request. A stalled result
// stays in the output register while the queue keeps taking requests. The
// user must write configuration on the cfg channel, always ready, only while
// the block is idle; the block does not enforce this. Reset empties the table
// and the queue, clears the byte counter and loads the register reset values.
// ----------------------------------------------------------------------------
module dirty_range_sync_tracker
    import drst_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [((ADDR_WIDTH > THR_W) ? ADDR_WIDTH : THR_W)-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADDR_WIDTH-1:0] i_write_position,
    input  logic [LEN_W-1:0]      i_write_length,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_sync_valid,
    output logic [ADDR_WIDTH-1:0] o_sync_start,
    output logic [ADDR_WIDTH-1:0] o_sync_length,
    output logic                  o_last
);

    localparam int ITEM_W = STATUS_W + LEN_W + 2 * ADDR_WIDTH;

    logic [ADDR_WIDTH-1:0] r_device_size;
    logic [THR_W-1:0]      r_sync_threshold;
    logic [SHIFT_W-1:0]    r_page_shift;

    logic                  w_push;
    logic                  w_pop;
    logic [ITEM_W-1:0]     w_push_item;
    logic [ITEM_W-1:0]     w_head_item;
    t_fifo_stat            w_fifo_stat;
    logic [ADDR_WIDTH-1:0] w_page_mask;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_size    <= '0;
            r_sync_threshold <= THRESHOLD_RST;
            r_page_shift     <= PAGE_SHIFT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEVICE_SIZE: begin
                    r_device_size <= i_cfg_data[ADDR_WIDTH-1:0];
                end
                CFG_SYNC_THRESHOLD: begin
                    r_sync_threshold <= i_cfg_data[THR_W-1:0];
                end
                CFG_PAGE_SHIFT: begin
                    r_page_shift <= i_cfg_data[SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    drst_front #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_position    (i_write_position),
        .i_length      (i_write_length),
        .i_device_size (r_device_size),
        .i_fifo_stat   (w_fifo_stat),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    drst_fifo #(
        .W (ITEM_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_item),
        .i_pop   (w_pop),
        .o_data  (w_head_item),
        .o_stat  (w_fifo_stat)
    );

    drst_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_WIDTH  (ADDR_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sync_threshold (r_sync_threshold),
        .i_page_shift     (r_page_shift),
        .i_fifo_stat      (w_fifo_stat),
        .i_item           (w_head_item),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_sync_valid     (o_sync_valid),
        .o_sync_start     (o_sync_start),
        .o_sync_length    (o_sync_length),
        .o_last           (o_last)
    );

    assign w_page_mask = {ADDR_WIDTH{1'b1}} << r_page_shift;

    // The queue never sees a push while full or a pop while empty.
    a_fifo_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_fifo_stat.full) && !(w_pop && w_fifo_stat.empty))
        else $error("request queue overflow or underflow");

    // Only flush commands may be followed by more results for one request.
    a_not_last_is_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> o_sync_valid)
        else $error("non-final result without a sync command");

    // Refused requests give a single result and carry no sync command.
    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_last && !o_sync_valid))
        else $error("error result is not a single plain result");

    // Sync starts are page aligned.
    a_sync_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sync_valid) |-> ((o_sync_start & ~w_page_mask) == '0))
        else $error("sync start not page aligned");

endmodule

// ----- sv/drst_front.sv -----
// ----------------------------------------------------------------------------
// drst_front
// Accepts write requests, computes the range end and classifies each
// request against the device size before it enters the queue.
// ----------------------------------------------------------------------------
module drst_front
    import drst_pkg::*;
#(
    parameter int ADDR_WIDTH = ADDR_WIDTH_DEF,
    parameter int ITEM_W     = STATUS_W + LEN_W + 2 * ADDR_WIDTH
) (
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADDR_WIDTH-1:0] i_position,
    input  logic [LEN_W-1:0]      i_length,
    input  logic [ADDR_WIDTH-1:0] i_device_size,
    input  t_fifo_stat            i_fifo_stat,
    output logic                  o_push,
    output logic [ITEM_W-1:0]     o_item
);

    localparam int EW = ((ADDR_WIDTH > LEN_W) ? ADDR_WIDTH : LEN_W) + 1;

    logic [EW-1:0] w_end;
    t_status       w_status;

    // The sum is kept one bit wider so a carry still counts as outside.
    assign w_end = EW'(i_position) + EW'(i_length);

    always_comb begin
        if (i_position >= i_device_size) begin
            w_status = ST_POS_OUT;
        end else if (w_end >= EW'(i_device_size)) begin
            w_status = ST_WRITE_OUT;
        end else begin
            w_status = ST_OK;
        end
    end

    assign o_in_stall = i_fifo_stat.full;
    assign o_push     = i_in_valid && !i_fifo_stat.full;
    assign o_item     = {w_status, i_length, w_end[ADDR_WIDTH-1:0], i_position};

endmodule

// ----- sv/drst_fifo.sv -----
// ----------------------------------------------------------------------------
// drst_fifo
// Short queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module drst_fifo
    import drst_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_fifo_stat   o_stat
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [W-1:0]  r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(FIFO_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(FIFO_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == CW'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ----- sv/drst_back.sv -----
// ----------------------------------------------------------------------------
// drst_back
// Range table, saturating byte counter and flush walker. Each item is
// compared against all live entries in the compare state, applied in the
// update state, and a flush then emits one sync command per entry.
// ----------------------------------------------------------------------------
module drst_back
    import drst_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    parameter int ITEM_W      = STATUS_W + LEN_W + 2 * ADDR_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [THR_W-1:0]      i_sync_threshold,
    input  logic [SHIFT_W-1:0]    i_page_shift,
    input  t_fifo_stat            i_fifo_stat,
    input  logic [ITEM_W-1:0]     i_item,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic                  o_sync_valid,
    output logic [ADDR_WIDTH-1:0] o_sync_start,
    output logic [ADDR_WIDTH-1:0] o_sync_length,
    output logic                  o_last
);

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state r_state;
    t_state n_state;

    // Current item.
    logic [ADDR_WIDTH-1:0] r_pos;
    logic [ADDR_WIDTH-1:0] r_end;
    logic [LEN_W-1:0]      r_len;
    t_status               r_status;

    // Compare results.
    logic [QUEUE_DEPTH-1:0] r_hit_oh;
    logic                   r_hit_any;
    logic                   r_hit_start;

    // Table and counters.
    logic [ADDR_WIDTH-1:0] r_rs [QUEUE_DEPTH];
    logic [ADDR_WIDTH-1:0] r_re [QUEUE_DEPTH];
    logic [CW-1:0]         r_cnt;
    logic [UNSYNC_W-1:0]   r_unsync;
    logic [IW-1:0]         r_fidx;

    // Output register.
    logic                  r_ov;
    t_status               r_ostatus;
    logic                  r_osv;
    logic [ADDR_WIDTH-1:0] r_ostart;
    logic [ADDR_WIDTH-1:0] r_olen;
    logic                  r_olast;

    logic [QUEUE_DEPTH-1:0] w_hs;
    logic [QUEUE_DEPTH-1:0] w_he;
    logic [QUEUE_DEPTH-1:0] w_first;
    logic                   w_seen;

    logic [UNSYNC_W:0]     w_sum;
    logic [UNSYNC_W-1:0]   w_newcnt;
    logic                  w_full;
    logic                  w_append;
    logic                  w_do_flush;
    logic                  w_out_free;
    logic                  w_upd_go;
    logic                  w_fl_go;
    logic [ADDR_WIDTH-1:0] w_mask;
    logic [ADDR_WIDTH-1:0] w_fa;
    logic [ADDR_WIDTH-1:0] w_fl;
    logic                  w_flast;

    // Parallel range compare with first-match priority.
    always_comb begin
        w_seen = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_hs[i] = (CW'(i) < r_cnt) && (r_pos >= r_rs[i]) && (r_pos <= r_re[i]);
            w_he[i] = (CW'(i) < r_cnt) && (r_end >= r_rs[i]) && (r_end <= r_re[i]);
            w_first[i] = (w_hs[i] || w_he[i]) && !w_seen;
            w_seen = w_seen || w_hs[i] || w_he[i];
        end
    end

    assign w_sum      = {1'b0, r_unsync} + (UNSYNC_W + 1)'(r_len);
    assign w_newcnt   = w_sum[UNSYNC_W] ? {UNSYNC_W{1'b1}} : w_sum[UNSYNC_W-1:0];
    assign w_full     = !r_hit_any && (r_cnt == CW'(QUEUE_DEPTH));
    assign w_append   = !r_hit_any && !w_full;
    assign w_do_flush = (r_status == ST_OK)
                        && (w_full || (w_newcnt >= UNSYNC_W'(i_sync_threshold)));
    assign w_out_free = !r_ov || !i_out_stall;

    // The update step waits for a free output slot, even when it only starts a flush.
    assign w_upd_go = (r_state == S_UPD) && w_out_free;
    assign w_fl_go  = (r_state == S_FLUSH) && w_out_free;

    assign w_mask  = {ADDR_WIDTH{1'b1}} << i_page_shift;
    assign w_fa    = r_rs[r_fidx] & w_mask;
    assign w_fl    = r_re[r_fidx] - w_fa;
    assign w_flast = ((CW'(r_fidx) + CW'(1)) == r_cnt);

    assign o_pop = !i_fifo_stat.empty
                   && ((r_state == S_IDLE) || (w_upd_go && !w_do_flush));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (w_upd_go) begin
                    if (w_do_flush) begin
                        n_state = S_FLUSH;
                    end else if (o_pop) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (w_fl_go && w_flast) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_unsync <= '0;
            r_fidx   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_upd_go && (r_status == ST_OK)) begin
                r_cnt <= r_cnt + CW'(w_append);
                if (w_do_flush) begin
                    r_unsync <= '0;
                    r_fidx   <= '0;
                end else begin
                    r_unsync <= w_newcnt;
                end
            end
            if (w_fl_go) begin
                if (w_flast) begin
                    r_cnt <= '0;
                end else begin
                    r_fidx <= r_fidx + IW'(1);
                end
            end
            if ((w_upd_go && !w_do_flush) || w_fl_go) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pos    <= i_item[ADDR_WIDTH-1:0];
            r_end    <= i_item[2*ADDR_WIDTH-1:ADDR_WIDTH];
            r_len    <= i_item[2*ADDR_WIDTH+LEN_W-1:2*ADDR_WIDTH];
            r_status <= t_status'(i_item[ITEM_W-1:2*ADDR_WIDTH+LEN_W]);
        end
        if (r_state == S_CMP) begin
            r_hit_oh    <= w_first;
            r_hit_any   <= |w_first;
            r_hit_start <= |(w_first & w_hs);
        end
        if (w_upd_go && (r_status == ST_OK)) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (r_hit_oh[i]) begin
                    if (r_hit_start) begin
                        if (r_end > r_re[i]) begin
                            r_re[i] <= r_end;
                        end
                    end else if (r_pos < r_rs[i]) begin
                        r_rs[i] <= r_pos;
                    end
                end else if (w_append && (CW'(i) == r_cnt)) begin
                    r_rs[i] <= r_pos;
                    r_re[i] <= r_end;
                end
            end
        end
        if (w_upd_go && !w_do_flush) begin
            r_ostatus <= r_status;
            r_osv     <= 1'b0;
            r_ostart  <= '0;
            r_olen    <= '0;
            r_olast   <= 1'b1;
        end else if (w_fl_go) begin
            r_ostatus <= ST_OK;
            r_osv     <= 1'b1;
            r_ostart  <= w_fa;
            r_olen    <= w_fl;
            r_olast   <= w_flast;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_ostatus;
    assign o_sync_valid  = r_osv;
    assign o_sync_start  = r_ostart;
    assign o_sync_length = r_olen;
    assign o_last        = r_olast;

endmodule

// ----- tb/tb_dirty_range_sync_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dirty_range_sync_tracker
// Self-checking bench for the dirty range tracker. A scoreboard class keeps
// its own copy of the range table, byte counter and registers, predicts the
// status or sync commands for every accepted write request, and checks each
// result transaction in order. Directed requests cover refusals, merges,
// threshold and table-full flushes; random phases vary the registers and
// throttle both channels, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_dirty_range_sync_tracker;
    import drst_pkg::*;

    localparam int AW          = ADDR_WIDTH_DEF;
    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int CFG_W       = (AW > THR_W) ? AW : THR_W;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        t_status         status;
        logic            sync_valid;
        logic [AW-1:0]   sync_start;
        logic [AW-1:0]   sync_length;
        logic            last;
    } t_sync_result;

    class dirty_range_scoreboard;
        logic [63:0]  device_size;
        logic [63:0]  sync_threshold;
        int           page_shift;
        logic [63:0]  range_lo [DEPTH];
        logic [63:0]  range_hi [DEPTH];
        int           range_count;
        logic [63:0]  unsynced;
        t_sync_result awaited [$];
        int           mismatch_count;

        function new();
            device_size    = '0;
            sync_threshold = 64'(THRESHOLD_RST);
            page_shift     = int'(PAGE_SHIFT_RST);
            range_count    = 0;
            unsynced       = '0;
            mismatch_count = 0;
        endfunction

        function void note_config(t_cfg_reg idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_DEVICE_SIZE:    device_size = 64'(data[AW-1:0]);
                CFG_SYNC_THRESHOLD: sync_threshold = 64'(data[THR_W-1:0]);
                CFG_PAGE_SHIFT:     page_shift = int'(data[SHIFT_W-1:0]);
                default: ;
            endcase
        endfunction

        // Works out the result transactions that one write request causes.
        function void note_write(logic [AW-1:0] pos, logic [LEN_W-1:0] len);
            logic [63:0]  lo;
            logic [63:0]  hi;
            logic [63:0]  mask;
            logic [63:0]  aligned;
            logic [63:0]  span;
            t_sync_result r;
            bit           matched;
            bit           table_full;
            lo = 64'(pos);
            hi = lo + 64'(len);
            r = '0;
            r.last = 1'b1;
            if (lo >= device_size) begin
                r.status = ST_POS_OUT;
                awaited.push_back(r);
                return;
            end
            if (hi >= device_size) begin
                r.status = ST_WRITE_OUT;
                awaited.push_back(r);
                return;
            end
            unsynced = unsynced + 64'(len);
            if (unsynced > (64'd1 << UNSYNC_W) - 64'd1)
                unsynced = (64'd1 << UNSYNC_W) - 64'd1;

            // The first entry that holds the new start or the new end absorbs it.
            matched = 1'b0;
            for (int i = 0; i < range_count && !matched; i++) begin
                if (lo >= range_lo[i] && lo <= range_hi[i]) begin
                    if (hi > range_hi[i])
                        range_hi[i] = hi;
                    matched = 1'b1;
                end else if (hi >= range_lo[i] && hi <= range_hi[i]) begin
                    if (lo < range_lo[i])
                        range_lo[i] = lo;
                    matched = 1'b1;
                end
            end
            table_full = 1'b0;
            if (!matched) begin
                if (range_count >= DEPTH) begin
                    table_full = 1'b1;
                end else begin
                    range_lo[range_count] = lo;
                    range_hi[range_count] = hi;
                    range_count++;
                end
            end
            if (!table_full && unsynced < sync_threshold) begin
                r.status = ST_OK;
                awaited.push_back(r);
                return;
            end

            mask = ~((64'd1 << page_shift) - 64'd1);
            for (int i = 0; i < range_count; i++) begin
                aligned = range_lo[i] & mask;
                span = range_hi[i] - aligned;
                r.status = ST_OK;
                r.sync_valid = 1'b1;
                r.sync_start = aligned[AW-1:0];
                r.sync_length = span[AW-1:0];
                r.last = (i == range_count - 1);
                awaited.push_back(r);
            end
            range_count = 0;
            unsynced = '0;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(t_sync_result got);
            t_sync_result want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d start %0h",
                         $time, got.status, got.sync_start);
                mismatch_count++;
                return;
            end
            want = awaited.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("sync_valid", 64'(want.sync_valid), 64'(got.sync_valid));
            compare_field("sync_start", 64'(want.sync_start), 64'(got.sync_start));
            compare_field("sync_length", 64'(want.sync_length), 64'(got.sync_length));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [AW-1:0]        i_write_position = '0;
    logic [LEN_W-1:0]     i_write_length = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_sync_valid;
    logic [AW-1:0]        o_sync_start;
    logic [AW-1:0]        o_sync_length;
    logic                 o_last;

    bit calm = 1'b0;
    bit long_hold_req = 1'b0;

    dirty_range_scoreboard sb = new();

    dirty_range_sync_tracker i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_write_position (i_write_position),
        .i_write_length   (i_write_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_sync_valid     (o_sync_valid),
        .o_sync_start     (o_sync_start),
        .o_sync_length    (o_sync_length),
        .o_last           (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_sync_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = t_status'(o_status);
            got.sync_valid = o_sync_valid;
            got.sync_start = o_sync_start;
            got.sync_length = o_sync_length;
            got.last = o_last;
            sb.check_result(got);
        end
    end

    // Result receiver. A requested long hold-off lets the request queue fill up.
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_out_stall = 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic write_reg(t_cfg_reg idx, logic [63:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.note_config(idx, value[CFG_W-1:0]);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [63:0] dev, logic [63:0] thr, int shift);
        write_reg(CFG_DEVICE_SIZE, dev);
        write_reg(CFG_SYNC_THRESHOLD, thr);
        write_reg(CFG_PAGE_SHIFT, 64'(shift));
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_write(logic [63:0] pos, logic [63:0] len);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_write_position = pos[AW-1:0];
        i_write_length = len[LEN_W-1:0];
        do @(posedge i_clk); while (o_in_stall);
        sb.note_write(pos[AW-1:0], len[LEN_W-1:0]);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (sb.awaited.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        logic [63:0] dev;
        logic [63:0] base;
        logic [63:0] r;
        logic [63:0] pos;
        logic [63:0] len;
        logic [63:0] thr;
        int          shift;
        int          sel;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Device size is zero out of reset, so everything is refused.
        send_write(64'd0, 64'd0);
        settle();

        set_config(64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF, 9);
        send_write(64'hFFFF_FFFF_FFFF, 64'd0);
        send_write(64'hFFFF_FFFF_FFFE, 64'd1);
        send_write(64'd0, 64'd0);
        // Maximum length reaches the maximum threshold and flushes at once.
        send_write(64'd0, 64'hFFFF_FFFF);
        send_write(64'h1000, 64'd100);
        send_write(64'h1050, 64'd200);
        send_write(64'h0F00, 64'd300);
        // Fill the table with disjoint ranges, then overflow it.
        for (int k = 1; k <= DEPTH; k++)
            send_write((64'(k) << 44) | 64'h321, 64'd64);
        settle();

        // Zero threshold flushes on every accepted write.
        set_config(64'hFFFF_FFFF_FFFF, 64'd0, 31);
        send_write(64'h1234_5678_9ABC, 64'd5000);
        send_write(64'h7FFF_FFFF, 64'd1);

        for (int p = 0; p < 5; p++) begin
            settle();
            calm = (p == 2);
            if (p == 4)
                dev = 64'hFFFF_FFFF_FFFF;
            else if (p % 2 == 1)
                dev = {16'd0, 16'($urandom_range(1, 65535)), 32'($urandom)};
            else
                dev = 64'd20000 + 64'($urandom_range(0, 50000));
            if (p == 1)
                thr = 64'd1;
            else if (p == 3)
                thr = 64'hFFFF_FFFF;
            else
                thr = 64'($urandom_range(2000, 30000));
            case (p)
                0: shift = 16;
                1: shift = 0;
                2: shift = 13;
                3: shift = 9;
                default: shift = $urandom_range(0, 31);
            endcase
            set_config(dev, thr, shift);
            // Requests cluster in one window so that ranges merge and the table fills.
            r = {32'($urandom), 32'($urandom)};
            base = r % (dev >> 1);
            if (p == 0)
                long_hold_req = 1'b1;
            repeat (15) begin
                r = {32'($urandom), 32'($urandom)};
                sel = $urandom_range(0, 19);
                case (sel)
                    0: begin
                        pos = {16'd0, r[47:0]};
                        len = 64'($urandom);
                    end
                    1: begin
                        pos = dev - 64'($urandom_range(1, 64));
                        len = 64'($urandom_range(0, 128));
                    end
                    2: begin
                        pos = base + 64'($urandom_range(0, 8191));
                        len = 64'($urandom_range(0, 4000));
                    end
                    default: begin
                        pos = base + 64'($urandom_range(0, 8191));
                        len = 64'($urandom_range(0, 600));
                    end
                endcase
                send_write(pos, len);
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (sb.mismatch_count == 0 && sb.awaited.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
